[hdl/stt_pkg.sv]
// package for the software timer table: sizes, codes and word types
// no dependencies
`default_nettype none
package stt_pkg;
  localparam int TableDepth = 16;
  localparam int MaxResults = 16;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_DEL = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NULL = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  timer_id;
    logic [31:0] countdown;
  } in_word_t;

  typedef struct packed {
    logic        fired;
    logic [7:0]  fired_id;
    logic [1:0]  status;
    logic [31:0] tick_count;
    logic        last;
  } out_word_t;
endpackage
`default_nettype wire

[hdl/stt_front.sv]
// front end: takes command words and queues them for the table walker
// depends on stt_pkg
`default_nettype none
module stt_front import stt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          q_valid,
  output in_word_t      q_word,
  input  wire logic     q_pop
);
  // two-entry queue
  in_word_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign busy = cnt_r[1];
  assign q_valid = (cnt_r != 2'd0);
  assign q_word = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (start && !busy) begin
        mem_r[wp_r] <= in_word;
        wp_r <= ~wp_r;
      end
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, start && !busy} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

[hdl/stt_back.sv]
// back end: walks the timer table one entry per cycle and emits result words
// depends on stt_pkg
`default_nettype none
module stt_back import stt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire in_word_t q_word,
  output logic          q_pop,
  output logic          out_strobe,
  output out_word_t     out_word
);
  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  state_t            state_r;
  logic [31:0]       cd_r [TableDepth];
  logic [7:0]        id_r [TableDepth];
  logic [CntW-1:0]   count_r, rd_r, wr_r;
  logic [CntW-1:0]   nhit_r;
  logic [31:0]       ticks_r;
  in_word_t          cmd_r;
  logic              hold_v_r;
  logic [7:0]        hold_id_r;
  logic              strobe_r, strobe_nxt;
  out_word_t         word_r, word_nxt;
  logic [31:0]       cur_cd;
  logic [7:0]        cur_id;
  logic              expired, keep, add_store;

  assign cur_cd = cd_r[rd_r[IdxW-1:0]];
  assign cur_id = id_r[rd_r[IdxW-1:0]];
  assign expired = (cur_cd <= 32'd1);
  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign add_store = (q_word.timer_id != 8'd0) && (q_word.countdown != 32'd0) &&
                     (count_r < CntW'(TableDepth));
  assign out_strobe = strobe_r;
  assign out_word = word_r;

  // per-entry keep decision during the walk
  always_comb begin
    keep = 1'b1;
    case (cmd_r.kind)
      KIND_DEL:  keep = (cur_id != cmd_r.timer_id);
      KIND_TICK: keep = !(expired && nhit_r < CntW'(MaxResults));
      default:   keep = 1'b1;
    endcase
  end

  // next result word; a fired id is held back one hit so the final one carries last
  always_comb begin
    strobe_nxt = 1'b0;
    word_nxt = '{fired: 1'b0, fired_id: 8'd0, status: ST_OK,
                 tick_count: ticks_r, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_word.kind)
            KIND_ADD: begin
              strobe_nxt = 1'b1;
              if (q_word.timer_id == 8'd0) begin
                word_nxt.status = ST_NULL;
              end else if (q_word.countdown == 32'd0) begin
                word_nxt.fired = 1'b1;
                word_nxt.fired_id = q_word.timer_id;
              end else if (count_r >= CntW'(TableDepth)) begin
                word_nxt.status = ST_FULL;
              end
            end
            KIND_DEL, KIND_TICK: strobe_nxt = 1'b0;
            default: strobe_nxt = 1'b1;
          endcase
        end
      end
      S_WALK: begin
        if (rd_r != count_r && !keep && cmd_r.kind == KIND_TICK && hold_v_r) begin
          strobe_nxt = 1'b1;
          word_nxt = '{fired: 1'b1, fired_id: hold_id_r, status: ST_OK,
                       tick_count: ticks_r + 32'd1, last: 1'b0};
        end
      end
      S_DONE: begin
        strobe_nxt = 1'b1;
        word_nxt = '{fired: hold_v_r, fired_id: hold_v_r ? hold_id_r : 8'd0,
                     status: ST_OK,
                     tick_count: (cmd_r.kind == KIND_TICK) ? ticks_r + 32'd1 : ticks_r,
                     last: 1'b1};
      end
      default: strobe_nxt = 1'b0;
    endcase
  end

  // sequencer, table storage and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ticks_r <= '0;
      strobe_r <= 1'b0;
      rd_r <= '0;
      wr_r <= '0;
      nhit_r <= '0;
      hold_v_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
      word_r <= word_nxt;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_word;
            rd_r <= '0;
            wr_r <= '0;
            nhit_r <= '0;
            case (q_word.kind)
              KIND_ADD: begin
                if (add_store) begin
                  cd_r[count_r[IdxW-1:0]] <= q_word.countdown;
                  id_r[count_r[IdxW-1:0]] <= q_word.timer_id;
                  count_r <= count_r + 1'b1;
                end
              end
              KIND_DEL, KIND_TICK: state_r <= S_WALK;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_WALK: begin
          if (rd_r == count_r) begin
            count_r <= wr_r;
            state_r <= S_DONE;
          end else begin
            rd_r <= rd_r + 1'b1;
            if (keep) begin
              cd_r[wr_r[IdxW-1:0]] <= (cmd_r.kind == KIND_TICK) ?
                (expired ? 32'd0 : cur_cd - 32'd1) : cur_cd;
              id_r[wr_r[IdxW-1:0]] <= cur_id;
              wr_r <= wr_r + 1'b1;
            end else if (cmd_r.kind == KIND_TICK) begin
              // expired entry: hold its id until the next hit or the end of the walk
              nhit_r <= nhit_r + 1'b1;
              hold_v_r <= 1'b1;
              hold_id_r <= cur_id;
            end
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
          hold_v_r <= 1'b0;
          if (cmd_r.kind == KIND_TICK) ticks_r <= ticks_r + 32'd1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/software_timer_table.sv]
// top level of the software timer table
// depends on stt_pkg, stt_front, stt_back
`default_nettype none
// Insertion-ordered table of 16 one-shot timers. A command word is taken when
// start is high and busy is low; two words can queue ahead of the walker and
// busy is high while both slots are taken. An add or an unused kind gives its
// result word via the front queue and result register; the walker takes one
// such word a cycle while not walking. A delete or a tick walks the table one
// entry a cycle, and its done state gives the final word. A tick gives one
// word per expired entry in table order, the final one marked last, or one
// word with fired low if none expired. Results appear for one cycle under
// out_strobe and cannot be stalled.
module software_timer_table import stt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_strobe,
  output out_word_t     out_word
);
  logic     q_valid, q_pop;
  in_word_t q_word;

  stt_front u_front (.clk, .rst_n, .start, .busy, .in_word,
    .q_valid, .q_word, .q_pop);
  stt_back u_back (.clk, .rst_n, .q_valid, .q_word, .q_pop,
    .out_strobe, .out_word);
endmodule
`default_nettype wire
